/* rtl/pccr_pkg.sv */
// ----------------------------------------------------------------------------
// pccr_pkg
// Shared types, phase codes and the CRC-32 byte step for the chunk CRC
// rewriter.
// ----------------------------------------------------------------------------
package pccr_pkg;

    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 16;
    localparam int CRC_W    = 32;
    localparam int LEN_W    = 32;
    // Position only has to match a 16-bit start; one extra bit marks "past".
    localparam int POS_W    = CFG_W + 1;
    localparam int PHASE_W  = 3;
    localparam int HCNT_W   = 3;
    localparam int BURST_N  = 4;
    localparam int BCNT_W   = 3;
    localparam int BIDX_W   = 2;

    localparam logic [CFG_W-1:0] CHUNK_START_RST = 16'd8;
    localparam logic [CRC_W-1:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT        = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_XOROUT      = 32'hFFFF_FFFF;

    localparam logic [PHASE_W-1:0] PH_SKIP = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEN  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_TYPE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd3;
    localparam logic [PHASE_W-1:0] PH_HOLD = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE = 3'd5;

    localparam logic [HCNT_W-1:0] HCNT_LAST = 3'd3;

    typedef logic [BYTE_W-1:0] t_byte;

    // One group of results caused by a single request.
    typedef struct packed {
        t_byte [BURST_N-1:0] bytes;
        logic [BCNT_W-1:0]   cnt;
        logic                rewritten;
        logic                fin;
    } t_burst;

    // Reflected CRC-32 update over one byte.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input t_byte b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = CRC_POLY ^ (c >> 1);
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/pccr_if.sv */
// ----------------------------------------------------------------------------
// pccr_in_if / pccr_out_if
// Valid/ready channels for the stream bytes in and the result bytes out.
// ----------------------------------------------------------------------------
interface pccr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       final_byte;

    modport source(output valid, output byte_in, output final_byte, input ready);
    modport sink(input valid, input byte_in, input final_byte, output ready);
endinterface

interface pccr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       rewritten;
    logic       stream_end;
    logic       run_last;

    modport source(output valid, output byte_out, output rewritten,
                   output stream_end, output run_last, input ready);
    modport sink(input valid, input byte_out, input rewritten,
                 input stream_end, input run_last, output ready);
endinterface

/* rtl/pccr_core.sv */
// ----------------------------------------------------------------------------
// pccr_core
// Input register, chunk parser state and CRC accumulator. Each advanced
// request produces one burst of zero to four result bytes.
// ----------------------------------------------------------------------------
module pccr_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pccr_pkg::CFG_W-1:0]  i_cfg_data,
    pccr_in_if.sink                     i_in,
    input  logic                        i_burst_free,
    output logic                        o_burst_load,
    output pccr_pkg::t_burst            o_burst
);
    import pccr_pkg::*;

    logic [CFG_W-1:0]   r_chunk_start;
    logic               r_in_valid;
    t_byte              r_byte;
    logic               r_fin;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [CRC_W-1:0]   r_crc, n_crc;
    logic [HCNT_W-1:0]  r_hcnt, n_hcnt;
    t_byte              r_held [BURST_N];
    t_byte              n_held [BURST_N];

    logic               adv;
    logic [PHASE_W-1:0] ph;
    logic [HCNT_W-1:0]  hc;
    logic [CRC_W-1:0]   crc_fin;
    t_burst             burst;

    assign adv        = r_in_valid && i_burst_free;
    assign i_in.ready = !r_in_valid || adv;
    assign crc_fin    = r_crc ^ CRC_XOROUT;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_len   = r_len;
        n_crc   = r_crc;
        n_hcnt  = r_hcnt;
        for (int i = 0; i < BURST_N; i++) begin
            n_held[i] = r_held[i];
        end
        burst           = '0;
        burst.fin       = r_fin;

        ph = r_phase;
        hc = r_hcnt;
        if (r_phase == PH_SKIP && r_pos == {1'b0, r_chunk_start}) begin
            ph = PH_LEN;
            hc = '0;
        end

        unique case (ph)
            PH_LEN: begin
                n_len          = {r_len[LEN_W-BYTE_W-1:0], r_byte};
                burst.bytes[0] = r_byte;
                burst.cnt      = BCNT_W'(1);
                if (hc == HCNT_LAST) begin
                    n_hcnt  = '0;
                    n_phase = PH_TYPE;
                end else begin
                    n_hcnt  = hc + HCNT_W'(1);
                    n_phase = PH_LEN;
                end
            end
            PH_TYPE: begin
                n_crc          = crc_byte(r_crc, r_byte);
                burst.bytes[0] = r_byte;
                burst.cnt      = BCNT_W'(1);
                if (hc == HCNT_LAST) begin
                    n_hcnt  = '0;
                    n_phase = (r_len == '0) ? PH_HOLD : PH_DATA;
                end else begin
                    n_hcnt  = hc + HCNT_W'(1);
                end
            end
            PH_DATA: begin
                n_crc          = crc_byte(r_crc, r_byte);
                burst.bytes[0] = r_byte;
                burst.cnt      = BCNT_W'(1);
                n_len          = r_len - LEN_W'(1);
                if (r_len == LEN_W'(1)) begin
                    n_phase = PH_HOLD;
                end
            end
            PH_HOLD: begin
                n_held[hc[BIDX_W-1:0]] = r_byte;
                if (hc == HCNT_LAST) begin
                    burst.bytes[0]  = crc_fin[31:24];
                    burst.bytes[1]  = crc_fin[23:16];
                    burst.bytes[2]  = crc_fin[15:8];
                    burst.bytes[3]  = crc_fin[7:0];
                    burst.cnt       = BCNT_W'(BURST_N);
                    burst.rewritten = 1'b1;
                    n_hcnt          = '0;
                    n_phase         = PH_DONE;
                end else begin
                    n_hcnt = hc + HCNT_W'(1);
                    // Stream cut short: flush the originals unchanged.
                    if (r_fin) begin
                        burst.cnt = BCNT_W'(hc) + BCNT_W'(1);
                        for (int i = 0; i < BURST_N; i++) begin
                            burst.bytes[i] = (BCNT_W'(i) == BCNT_W'(hc)) ? r_byte
                                                                         : r_held[i];
                        end
                    end
                end
            end
            default: begin
                burst.bytes[0] = r_byte;
                burst.cnt      = BCNT_W'(1);
            end
        endcase

        if (r_pos != {POS_W{1'b1}}) begin
            n_pos = r_pos + POS_W'(1);
        end

        if (r_fin) begin
            n_phase = PH_SKIP;
            n_pos   = '0;
            n_len   = '0;
            n_crc   = CRC_INIT;
            n_hcnt  = '0;
        end
    end

    assign o_burst      = burst;
    assign o_burst_load = adv && (burst.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_start <= CHUNK_START_RST;
            r_in_valid    <= 1'b0;
            r_phase       <= PH_SKIP;
            r_pos         <= '0;
            r_len         <= '0;
            r_crc         <= CRC_INIT;
            r_hcnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_chunk_start <= i_cfg_data;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_len   <= n_len;
                r_crc   <= n_crc;
                r_hcnt  <= n_hcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.byte_in;
            r_fin  <= i_in.final_byte;
        end
        if (adv) begin
            for (int i = 0; i < BURST_N; i++) begin
                r_held[i] <= n_held[i];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_hcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= HCNT_LAST)
        else $error("held count out of range");

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_fin |=> r_phase == PH_SKIP && r_pos == '0 && r_crc == CRC_INIT)
        else $error("stream state not cleared after final byte");

    a_hold_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_phase == PH_HOLD && r_hcnt != HCNT_LAST && !r_fin |-> !o_burst_load)
        else $error("held CRC byte produced a result");
`endif

endmodule

/* rtl/pccr_burst.sv */
// ----------------------------------------------------------------------------
// pccr_burst
// Result register for one burst; hands its bytes out one per cycle while the
// receiver is ready, and marks the last one of the burst.
// ----------------------------------------------------------------------------
module pccr_burst (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pccr_pkg::t_burst i_burst,
    output logic             o_free,
    pccr_out_if.source       o_out
);
    import pccr_pkg::*;

    logic                r_valid;
    t_byte [BURST_N-1:0] r_bytes;
    logic [BCNT_W-1:0]   r_cnt;
    logic [BIDX_W-1:0]   r_idx;
    logic                r_rw;
    logic                r_fin;

    logic                last;
    logic                take;

    assign last   = (BCNT_W'(r_idx) + BCNT_W'(1)) == r_cnt;
    assign take   = r_valid && o_out.ready;
    assign o_free = !r_valid || (take && last);

    assign o_out.valid      = r_valid;
    assign o_out.byte_out   = r_bytes[r_idx];
    assign o_out.rewritten  = r_rw;
    assign o_out.run_last   = last;
    assign o_out.stream_end = r_fin && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (o_free) begin
                r_valid <= i_load;
                r_idx   <= '0;
            end else if (take) begin
                // advance within the burst
                r_idx <= r_idx + BIDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_bytes <= i_burst.bytes;
            r_cnt   <= i_burst.cnt;
            r_rw    <= i_burst.rewritten;
            r_fin   <= i_burst.fin;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_cnt != '0 && r_cnt <= BCNT_W'(BURST_N))
        else $error("burst count out of range");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> BCNT_W'(r_idx) < r_cnt)
        else $error("burst index past count");

    a_rw_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_rw |-> r_cnt == BCNT_W'(BURST_N))
        else $error("rewritten burst not four bytes");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !o_out.ready |=> r_valid && $stable(r_idx))
        else $error("burst moved while stalled");
`endif

endmodule

/* rtl/png_chunk_crc_rewriter_unit.sv */
// ----------------------------------------------------------------------------
// png_chunk_crc_rewriter_unit
// Byte stream pass-through that recomputes the CRC-32 of one chunk.
// ----------------------------------------------------------------------------
//   i_in carries one stream byte per request, final_byte marking the last
//   byte of a stream. o_rsp carries the result bytes; run_last marks the last
//   result of a request, stream_end the last byte of the stream.
//   i_cfg_we/i_cfg_data write chunk_start (reset value 8); the user must write
//   it only while idle, which the block does not enforce. A request passes
//   the input register and then the burst register before its first result
//   can be taken. Throughput: one request per cycle while the burst register
//   is free. The output moves one byte per cycle while the receiver is ready,
//   so the four CRC bytes hold it, as does a flush of up to three held CRC
//   bytes at an early stream end; held CRC bytes give no result until then.
//   A stalled receiver holds the current byte; once the input and burst
//   registers are both full, i_in ready drops.
//   Synchronous reset clears the parser, CRC and both valid flags and sets
//   chunk_start to 8. After a final byte the parser returns to its reset
//   state by itself, keeping chunk_start.
// ----------------------------------------------------------------------------
module png_chunk_crc_rewriter_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pccr_pkg::CFG_W-1:0]  i_cfg_data,
    pccr_in_if.sink                     i_in,
    pccr_out_if.source                  o_rsp
);
    import pccr_pkg::*;

    logic   burst_free;
    logic   burst_load;
    t_burst burst;

    pccr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in         (i_in),
        .i_burst_free (burst_free),
        .o_burst_load (burst_load),
        .o_burst      (burst)
    );

    pccr_burst u_burst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (burst_load),
        .i_burst (burst),
        .o_free  (burst_free),
        .o_out   (o_rsp)
    );

endmodule
